// ----- sv/jcse_pkg.sv -----
// Shared constants, handshake structs and the TAP state step function for the
// JTAG command shift engine. No dependencies.
package jcse_pkg;

    // Parse phases of the host command stream.
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_LEN1 = 4'd1;
    localparam logic [3:0] PH_LEN2 = 4'd2;
    localparam logic [3:0] PH_DIVL = 4'd3;
    localparam logic [3:0] PH_DIVH = 4'd4;
    localparam logic [3:0] PH_BYTE = 4'd5;
    localparam logic [3:0] PH_BIT  = 4'd6;
    localparam logic [3:0] PH_SETV = 4'd7;
    localparam logic [3:0] PH_SETD = 4'd8;

    // Pin driven by a shift command.
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_TMS  = 2'd1;
    localparam logic [1:0] TGT_TDI  = 2'd2;

    localparam logic [3:0] TAP_SHIFT_IR = 4'd7;

    // Instruction command codes.
    localparam logic [7:0] CMD_SET_LO   = 8'h80;
    localparam logic [7:0] CMD_READ_LO  = 8'h81;
    localparam logic [7:0] CMD_SET_HI   = 8'h82;
    localparam logic [7:0] CMD_READ_HI  = 8'h83;
    localparam logic [7:0] CMD_LOOP_ON  = 8'h84;
    localparam logic [7:0] CMD_LOOP_OFF = 8'h85;
    localparam logic [7:0] CMD_DIVISOR  = 8'h86;
    localparam logic [7:0] CMD_FLUSH    = 8'h87;
    localparam logic [7:0] CMD_CLK_FAST = 8'h8A;
    localparam logic [7:0] CMD_CLK_SLOW = 8'h8B;

    // Reply codes.
    localparam logic [7:0] RPL_PINS      = 8'h00;
    localparam logic [7:0] RPL_BAD_CMD   = 8'hFA;
    localparam logic [7:0] RPL_MATCH     = 8'h80;
    localparam logic [7:0] RPL_SUBST     = 8'h90;
    localparam logic [7:0] INSTR_SPECIAL = 8'h41;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // accept the host byte now
        logic pulse;  // load one TCK pulse into the output register
        logic reply;  // load the pending reply byte
        logic echo;   // load the stored command byte as a reply
        logic last;   // mark the loaded result as the final one of its byte
    } jcse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dec_pulse;   // the offered byte starts a run of pulses
        logic dec_reply;   // the offered byte leads to a reply
        logic dec_echo;    // the offered byte is an unknown instruction
        logic pulse_last;  // the next pulse is the final one of the byte
        logic out_free;    // the output register can be loaded this cycle
    } jcse_stat_t;

    function automatic logic [3:0] tap_step(input logic tms, input logic [3:0] st);
        logic [3:0] nxt;
        case (st)
            4'd0:    nxt = tms ? 4'd0  : 4'd1;
            4'd1:    nxt = tms ? 4'd2  : 4'd1;
            4'd2:    nxt = tms ? 4'd3  : 4'd4;
            4'd3:    nxt = tms ? 4'd0  : 4'd5;
            4'd4:    nxt = tms ? 4'd8  : 4'd6;
            4'd5:    nxt = tms ? 4'd9  : 4'd7;
            4'd6:    nxt = tms ? 4'd8  : 4'd6;
            4'd7:    nxt = tms ? 4'd9  : 4'd7;
            4'd8:    nxt = tms ? 4'd14 : 4'd10;
            4'd9:    nxt = tms ? 4'd15 : 4'd11;
            4'd10:   nxt = tms ? 4'd12 : 4'd10;
            4'd11:   nxt = tms ? 4'd13 : 4'd11;
            4'd12:   nxt = tms ? 4'd14 : 4'd6;
            4'd13:   nxt = tms ? 4'd15 : 4'd7;
            4'd14:   nxt = tms ? 4'd2  : 4'd1;
            default: nxt = tms ? 4'd2  : 4'd1;
        endcase
        return nxt;
    endfunction

endpackage

// ----- sv/jcse_if.sv -----
// Handshake interfaces for the host byte channel and the result channel.
// No dependencies.
interface jcse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_byte;
    logic [7:0] tdo_samples;

    modport source (output valid, output host_byte, output tdo_samples, input ready);
    modport sink   (input valid, input host_byte, input tdo_samples, output ready);
endinterface

interface jcse_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        tms_level;
    logic        tdi_level;
    logic [7:0]  reply_byte;
    logic [15:0] clock_divisor;
    logic        clock_fast;
    logic [3:0]  tap_state;
    logic        last;

    modport source (output valid, output kind, output tms_level, output tdi_level,
                    output reply_byte, output clock_divisor, output clock_fast,
                    output tap_state, output last, input ready);
    modport sink   (input valid, input kind, input tms_level, input tdi_level,
                    input reply_byte, input clock_divisor, input clock_fast,
                    input tap_state, input last, output ready);
endinterface

// ----- sv/jcse_ctrl.sv -----
// Controller state machine of the JTAG command shift engine: sequences byte
// intake, TCK pulses and replies. Depends on jcse_pkg.
module jcse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jcse_pkg::jcse_stat_t stat,
    output jcse_pkg::jcse_cmd_t  cmd
);
    import jcse_pkg::*;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_PULSE = 2'd1;
    localparam logic [1:0] C_REPLY = 2'd2;
    localparam logic [1:0] C_ECHO  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       rep_reg, rep_next;
    logic       echo_reg, echo_next;

    always_comb
    begin
        state_next = state_reg;
        rep_next   = rep_reg;
        echo_next  = echo_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take  = 1'b1;
                    rep_next  = stat.dec_reply;
                    echo_next = stat.dec_echo;
                    if (stat.dec_pulse)
                        state_next = C_PULSE;
                    else if (stat.dec_reply)
                        state_next = C_REPLY;
                end
            end
            C_PULSE:
            begin
                if (stat.out_free)
                begin
                    cmd.pulse = 1'b1;
                    cmd.last  = stat.pulse_last && !rep_reg;
                    if (stat.pulse_last)
                        state_next = rep_reg ? C_REPLY : C_IDLE;
                end
            end
            C_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.reply  = 1'b1;
                    cmd.last   = !echo_reg;
                    state_next = echo_reg ? C_ECHO : C_IDLE;
                end
            end
            C_ECHO:
            begin
                if (stat.out_free)
                begin
                    cmd.echo   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rep_reg   <= 1'b0;
            echo_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rep_reg   <= rep_next;
            echo_reg  <= echo_next;
        end
    end

endmodule

// ----- sv/jcse_dp.sv -----
// Datapath of the JTAG command shift engine: command parser state, pin and
// TAP tracking, TDO capture and the output register. Depends on jcse_pkg.
module jcse_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           host_byte,
    input  logic [7:0]           tdo_samples,
    input  logic                 out_ready,
    input  jcse_pkg::jcse_cmd_t  cmd,
    output jcse_pkg::jcse_stat_t stat,
    output logic                 out_valid,
    output logic                 out_kind,
    output logic                 out_tms,
    output logic                 out_tdi,
    output logic [7:0]           out_reply,
    output logic [15:0]          out_div,
    output logic                 out_fast,
    output logic [3:0]           out_tap,
    output logic                 out_last
);
    import jcse_pkg::*;

    // Parser and pin state.
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] div_reg, div_next;
    logic        fast_reg, fast_next;
    logic [1:0]  tgt_reg, tgt_next;
    logic        tms_reg, tms_next;
    logic        tdi_reg, tdi_next;
    logic [3:0]  tap_reg, tap_next;
    logic [7:0]  instr_reg, instr_next;
    logic        ovalid_reg, ovalid_next;

    // Per-byte working registers.
    logic [7:0]  data_reg, data_next;
    logic [7:0]  tdo_reg, tdo_next;
    logic [7:0]  cap_reg, cap_next;
    logic [7:0]  reply_reg, reply_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  nlast_reg, nlast_next;
    logic        subst_reg, subst_next;

    // Output payload.
    logic        okind_reg, okind_next;
    logic        otms_reg, otms_next;
    logic        otdi_reg, otdi_next;
    logic [7:0]  oreply_reg, oreply_next;
    logic [15:0] odiv_reg, odiv_next;
    logic        ofast_reg, ofast_next;
    logic [3:0]  otap_reg, otap_next;
    logic        olast_reg, olast_next;

    logic        is_idle;
    logic        is_shift;
    logic        unknown;
    logic [2:0]  pos;
    logic        dbit;
    logic [7:0]  cap_step;
    logic        step_tms;
    logic        step_tdi;
    logic [3:0]  step_tap;

    assign is_idle  = (phase_reg == PH_IDLE);
    assign is_shift = (phase_reg == PH_BYTE) || (phase_reg == PH_BIT);
    assign unknown  = host_byte[7] && !(host_byte inside {[CMD_SET_LO : CMD_FLUSH],
                                                          CMD_CLK_FAST, CMD_CLK_SLOW});

    assign stat.dec_pulse  = is_shift;
    assign stat.dec_echo   = is_idle && unknown;
    assign stat.dec_reply  = (is_shift && cmd_reg[5]) ||
                             (is_idle && (unknown || host_byte == CMD_READ_LO ||
                                          host_byte == CMD_READ_HI));
    assign stat.pulse_last = (cnt_reg == nlast_reg);
    assign stat.out_free   = !ovalid_reg || out_ready;

    // MSB-first order drives position 7 - p, which is the complement of p.
    assign pos      = cmd_reg[3] ? cnt_reg : ~cnt_reg;
    assign dbit     = data_reg[pos];
    assign cap_step = cap_reg | (8'(tdo_reg[cnt_reg]) << pos);
    assign step_tms = (tgt_reg == TGT_TMS) ? dbit : tms_reg;
    assign step_tdi = (tgt_reg == TGT_TDI) ? dbit : tdi_reg;
    assign step_tap = (tgt_reg == TGT_TMS) ? tap_step(dbit, tap_reg) : tap_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        div_next    = div_reg;
        fast_next   = fast_reg;
        tgt_next    = tgt_reg;
        tms_next    = tms_reg;
        tdi_next    = tdi_reg;
        tap_next    = tap_reg;
        instr_next  = instr_reg;
        data_next   = data_reg;
        tdo_next    = tdo_reg;
        cap_next    = cap_reg;
        reply_next  = reply_reg;
        cnt_next    = cnt_reg;
        nlast_next  = nlast_reg;
        subst_next  = subst_reg;
        okind_next  = okind_reg;
        otms_next   = otms_reg;
        otdi_next   = otdi_reg;
        oreply_next = oreply_reg;
        odiv_next   = odiv_reg;
        ofast_next  = ofast_reg;
        otap_next   = otap_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !out_ready;

        if (cmd.take)
        begin
            data_next  = host_byte;
            tdo_next   = tdo_samples;
            cap_next   = 8'h00;
            cnt_next   = 3'd0;
            reply_next = unknown ? RPL_BAD_CMD : RPL_PINS;
            case (phase_reg)
                PH_IDLE:
                begin
                    cmd_next = host_byte;
                    if (!host_byte[7])
                    begin
                        if ((host_byte[6:4] != 3'b000) && host_byte[0])
                        begin
                            if (host_byte[6])
                                tgt_next = TGT_TMS;
                            else if (host_byte[4])
                                tgt_next = TGT_TDI;
                            else
                                tgt_next = TGT_NONE;
                            phase_next = PH_LEN1;
                        end
                    end
                    else
                    begin
                        case (host_byte)
                            CMD_SET_LO, CMD_SET_HI: phase_next = PH_SETV;
                            CMD_DIVISOR:            phase_next = PH_DIVL;
                            CMD_CLK_FAST:           fast_next  = 1'b1;
                            CMD_CLK_SLOW:           fast_next  = 1'b0;
                            default:                phase_next = PH_IDLE;
                        endcase
                    end
                end
                PH_LEN1:
                begin
                    len_next   = {8'h00, host_byte};
                    phase_next = cmd_reg[1] ? PH_BIT : PH_LEN2;
                end
                PH_LEN2:
                begin
                    len_next   = {host_byte, len_reg[7:0]};
                    phase_next = PH_BYTE;
                end
                PH_DIVL:
                begin
                    div_next   = {8'h00, host_byte};
                    phase_next = PH_DIVH;
                end
                PH_DIVH:
                begin
                    div_next   = {host_byte, div_reg[7:0]};
                    phase_next = PH_IDLE;
                end
                PH_BYTE:
                begin
                    nlast_next = 3'd7;
                    subst_next = 1'b1;
                    if (tgt_reg == TGT_TMS)
                        tdi_next = host_byte[7];
                    if (len_reg != 16'd0)
                        len_next = len_reg - 16'd1;
                    else
                        phase_next = PH_IDLE;
                end
                PH_BIT:
                begin
                    nlast_next = (len_reg > 16'd7) ? 3'd7 : len_reg[2:0];
                    subst_next = 1'b0;
                    if (tap_reg == TAP_SHIFT_IR && cmd_reg[4])
                        instr_next = host_byte;
                    if (tgt_reg == TGT_TMS)
                        tdi_next = host_byte[7];
                    phase_next = PH_IDLE;
                end
                PH_SETV:
                begin
                    phase_next = PH_SETD;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (cmd.pulse)
        begin
            tms_next    = step_tms;
            tdi_next    = step_tdi;
            tap_next    = step_tap;
            cap_next    = cap_step;
            cnt_next    = cnt_reg + 3'd1;
            if (stat.pulse_last)
            begin
                // Byte-mode replies read as the match code are remapped under
                // the special instruction.
                if (subst_reg && instr_reg == INSTR_SPECIAL && cap_step == RPL_MATCH)
                    reply_next = RPL_SUBST;
                else
                    reply_next = cap_step;
            end
            okind_next  = 1'b0;
            otms_next   = step_tms;
            otdi_next   = step_tdi;
            oreply_next = 8'h00;
            otap_next   = step_tap;
        end

        if (cmd.reply || cmd.echo)
        begin
            okind_next  = 1'b1;
            otms_next   = 1'b0;
            otdi_next   = 1'b0;
            oreply_next = cmd.echo ? cmd_reg : reply_reg;
            otap_next   = tap_reg;
        end

        if (cmd.pulse || cmd.reply || cmd.echo)
        begin
            odiv_next   = div_reg;
            ofast_next  = fast_reg;
            olast_next  = cmd.last;
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cmd_reg    <= 8'h00;
            len_reg    <= 16'h0000;
            div_reg    <= 16'h0000;
            fast_reg   <= 1'b0;
            tgt_reg    <= TGT_NONE;
            tms_reg    <= 1'b0;
            tdi_reg    <= 1'b0;
            tap_reg    <= 4'd0;
            instr_reg  <= 8'h00;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            div_reg    <= div_next;
            fast_reg   <= fast_next;
            tgt_reg    <= tgt_next;
            tms_reg    <= tms_next;
            tdi_reg    <= tdi_next;
            tap_reg    <= tap_next;
            instr_reg  <= instr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        tdo_reg    <= tdo_next;
        cap_reg    <= cap_next;
        reply_reg  <= reply_next;
        cnt_reg    <= cnt_next;
        nlast_reg  <= nlast_next;
        subst_reg  <= subst_next;
        okind_reg  <= okind_next;
        otms_reg   <= otms_next;
        otdi_reg   <= otdi_next;
        oreply_reg <= oreply_next;
        odiv_reg   <= odiv_next;
        ofast_reg  <= ofast_next;
        otap_reg   <= otap_next;
        olast_reg  <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_tms   = otms_reg;
    assign out_tdi   = otdi_reg;
    assign out_reply = oreply_reg;
    assign out_div   = odiv_reg;
    assign out_fast  = ofast_reg;
    assign out_tap   = otap_reg;
    assign out_last  = olast_reg;

endmodule

// ----- sv/jtag_command_shift_engine_core.sv -----
// Top level of the JTAG command shift engine: joins the controller and the
// datapath to the channels. Depends on jcse_pkg, jcse_if, jcse_ctrl, jcse_dp.
//
//   channel  modport  payload                                    item
//   host     sink     host_byte, tdo_samples                     one stream byte
//   result   source   kind, tms_level, tdi_level, reply_byte,    one TCK pulse or
//                     clock_divisor, clock_fast, tap_state, last one reply byte
//
// A host byte is taken while the controller is idle; each result it causes is then
// loaded into the output register in turn, as the register frees, and the next byte
// is taken once the last of them is loaded. The output register sets the pace.
// The next byte is taken while the final result still waits in the output register.
// A stalled result channel holds the sequencer at its current pulse or reply.
// Reset brings the parser to idle, TAP tracking to Test-Logic-Reset, pins low.
module jtag_command_shift_engine_core (
    input  logic         clk,
    input  logic         rst_n,
    jcse_in_if.sink      host,
    jcse_out_if.source   result
);
    import jcse_pkg::*;

    jcse_cmd_t  cmd;
    jcse_stat_t stat;

    jcse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (host.valid),
        .in_ready (host.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jcse_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .host_byte   (host.host_byte),
        .tdo_samples (host.tdo_samples),
        .out_ready   (result.ready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (result.valid),
        .out_kind    (result.kind),
        .out_tms     (result.tms_level),
        .out_tdi     (result.tdi_level),
        .out_reply   (result.reply_byte),
        .out_div     (result.clock_divisor),
        .out_fast    (result.clock_fast),
        .out_tap     (result.tap_state),
        .out_last    (result.last)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for jtag_command_shift_engine_core: drives host command
// streams and checks every pulse and reply item. Depends on jcse_pkg, jcse_if.
module tb;
    import jcse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LINES = 20;
    // Next TAP state per current state, four bits per state, state 0 lowest.
    localparam logic [63:0] TAP_AFTER_TMS0 = 64'h1176BABA76765411;
    localparam logic [63:0] TAP_AFTER_TMS1 = 64'h22FEDCFE98980320;

    typedef struct packed {
        logic        kind;
        logic        tms;
        logic        tdi;
        logic [7:0]  reply;
        logic [15:0] divisor;
        logic        fast;
        logic [3:0]  tap;
        logic        last;
    } shift_result_t;

    class shift_scoreboard;
        shift_result_t pending_results[$];
        shift_result_t staged[$];
        int mismatches;
        int checked;
        int pulses;
        int replies;
        int bytes_noted;

        logic [3:0]  phase;
        logic [7:0]  cmd;
        logic [15:0] rem_len;
        logic [15:0] divisor;
        logic        fast;
        logic [1:0]  target;
        logic        tms_pin;
        logic        tdi_pin;
        logic [3:0]  tap;
        logic [7:0]  last_instr;

        function new();
            phase = PH_IDLE;
            cmd = '0;
            rem_len = '0;
            divisor = '0;
            fast = 1'b0;
            target = TGT_NONE;
            tms_pin = 1'b0;
            tdi_pin = 1'b0;
            tap = '0;
            last_instr = '0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("%0t ns  MISMATCH: %s", $realtime, msg);
        endtask

        function logic [3:0] next_tap(logic tms_bit, logic [3:0] st);
            return tms_bit ? TAP_AFTER_TMS1[st*4 +: 4] : TAP_AFTER_TMS0[st*4 +: 4];
        endfunction

        function void add_reply(logic [7:0] value);
            shift_result_t r;
            r = '0;
            r.kind = 1'b1;
            r.reply = value;
            r.divisor = divisor;
            r.fast = fast;
            r.tap = tap;
            staged.push_back(r);
        endfunction

        // Drives the pulses of one data byte and returns the captured TDO byte.
        function logic [7:0] drive_pulses(logic [7:0] data, logic [7:0] tdo, int count);
            logic [7:0] cap;
            int pos;
            shift_result_t r;
            cap = '0;
            if (target == TGT_TMS)
                tdi_pin = data[7];
            for (int p = 0; p < count; p++) begin
                pos = cmd[3] ? p : 7 - p;
                if (target == TGT_TMS) begin
                    tms_pin = data[pos];
                    tap = next_tap(data[pos], tap);
                end else if (target == TGT_TDI) begin
                    tdi_pin = data[pos];
                end
                if (tdo[p])
                    cap[pos] = 1'b1;
                r = '0;
                r.tms = tms_pin;
                r.tdi = tdi_pin;
                r.divisor = divisor;
                r.fast = fast;
                r.tap = tap;
                staged.push_back(r);
            end
            return cap;
        endfunction

        function void note_byte(logic [7:0] b, logic [7:0] tdo);
            logic [7:0] cap;
            int count;
            staged.delete();
            bytes_noted++;
            case (phase)
                PH_IDLE: begin
                    cmd = b;
                    if (!b[7]) begin
                        if (b[6:4] != 3'b000 && b[0]) begin
                            target = b[6] ? TGT_TMS : (b[4] ? TGT_TDI : TGT_NONE);
                            phase = PH_LEN1;
                        end
                    end else begin
                        case (b)
                            CMD_SET_LO, CMD_SET_HI:   phase = PH_SETV;
                            CMD_READ_LO, CMD_READ_HI: add_reply(RPL_PINS);
                            CMD_LOOP_ON, CMD_LOOP_OFF, CMD_FLUSH: ;
                            CMD_DIVISOR:  phase = PH_DIVL;
                            CMD_CLK_FAST: fast = 1'b1;
                            CMD_CLK_SLOW: fast = 1'b0;
                            default: begin
                                add_reply(RPL_BAD_CMD);
                                add_reply(b);
                            end
                        endcase
                    end
                end
                PH_LEN1: begin
                    rem_len = {8'h00, b};
                    phase = cmd[1] ? PH_BIT : PH_LEN2;
                end
                PH_LEN2: begin
                    rem_len[15:8] = b;
                    phase = PH_BYTE;
                end
                PH_DIVL: begin
                    divisor = {8'h00, b};
                    phase = PH_DIVH;
                end
                PH_DIVH: begin
                    divisor[15:8] = b;
                    phase = PH_IDLE;
                end
                PH_BYTE: begin
                    cap = drive_pulses(b, tdo, 8);
                    if (cmd[5]) begin
                        if (last_instr == INSTR_SPECIAL && cap == RPL_MATCH)
                            cap = RPL_SUBST;
                        add_reply(cap);
                    end
                    if (rem_len != 16'd0)
                        rem_len--;
                    else
                        phase = PH_IDLE;
                end
                PH_BIT: begin
                    count = (rem_len > 16'd7 ? 7 : int'(rem_len)) + 1;
                    if (tap == TAP_SHIFT_IR && cmd[4])
                        last_instr = b;
                    cap = drive_pulses(b, tdo, count);
                    if (cmd[5])
                        add_reply(cap);
                    phase = PH_IDLE;
                end
                PH_SETV: phase = PH_SETD;
                default: phase = PH_IDLE;
            endcase
            if (staged.size() > 0)
                staged[staged.size() - 1].last = 1'b1;
            foreach (staged[i]) begin
                if (staged[i].kind)
                    replies++;
                else
                    pulses++;
                pending_results.push_back(staged[i]);
            end
        endfunction

        task check_result(shift_result_t got);
            shift_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("result %0d kind %0d, expected %0d",
                                 checked, got.kind, want.kind));
            if (got.tms !== want.tms)
                report($sformatf("result %0d tms_level %0d, expected %0d",
                                 checked, got.tms, want.tms));
            if (got.tdi !== want.tdi)
                report($sformatf("result %0d tdi_level %0d, expected %0d",
                                 checked, got.tdi, want.tdi));
            if (got.reply !== want.reply)
                report($sformatf("result %0d reply_byte %h, expected %h",
                                 checked, got.reply, want.reply));
            if (got.divisor !== want.divisor)
                report($sformatf("result %0d clock_divisor %h, expected %h",
                                 checked, got.divisor, want.divisor));
            if (got.fast !== want.fast)
                report($sformatf("result %0d clock_fast %0d, expected %0d",
                                 checked, got.fast, want.fast));
            if (got.tap !== want.tap)
                report($sformatf("result %0d tap_state %0d, expected %0d",
                                 checked, got.tap, want.tap));
            if (got.last !== want.last)
                report($sformatf("result %0d last %0d, expected %0d",
                                 checked, got.last, want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    int   bytes_sent;

    jcse_in_if  host_ch ();
    jcse_out_if result_ch ();

    shift_scoreboard sb = new();

    jtag_command_shift_engine_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .host   (host_ch),
        .result (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: sample the handshake of the edge, then decide ready for the next one.
    initial
    begin
        shift_result_t seen;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready) begin
                seen.kind    = result_ch.kind;
                seen.tms     = result_ch.tms_level;
                seen.tdi     = result_ch.tdi_level;
                seen.reply   = result_ch.reply_byte;
                seen.divisor = result_ch.clock_divisor;
                seen.fast    = result_ch.clock_fast;
                seen.tap     = result_ch.tap_state;
                seen.last    = result_ch.last;
                sb.check_result(seen);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [7:0] tdo);
        while ($urandom_range(99) < send_idle_pct) begin
            host_ch.valid <= 1'b0;
            @(posedge clk);
        end
        host_ch.valid       <= 1'b1;
        host_ch.host_byte   <= b;
        host_ch.tdo_samples <= tdo;
        do
            @(posedge clk);
        while (!host_ch.ready);
        sb.note_byte(b, tdo);
        bytes_sent++;
    endtask

    // The sender goes quiet so that no byte is offered twice while waiting.
    task automatic wait_drained();
        host_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One command with its length, data or argument bytes, or a stray byte.
    task automatic send_random_command();
        logic [7:0] known [10] = '{CMD_SET_LO, CMD_READ_LO, CMD_SET_HI, CMD_READ_HI,
                                   CMD_LOOP_ON, CMD_LOOP_OFF, CMD_DIVISOR, CMD_FLUSH,
                                   CMD_CLK_FAST, CMD_CLK_SLOW};
        logic [7:0] c;
        logic [7:0] data;
        logic [7:0] tdo;
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 70) begin
            c = 8'($urandom_range(255));
            c[7] = 1'b0;
            c[0] = 1'b1;
            if (c[6:4] == 3'b000)
                c[6:4] = 3'($urandom_range(7, 1));
            send_byte(c, 8'($urandom_range(255)));
            if (c[1]) begin
                send_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
                data = ($urandom_range(3) == 0) ? INSTR_SPECIAL : 8'($urandom_range(255));
                send_byte(data, 8'($urandom_range(255)));
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3);
                send_byte(len[7:0], 8'($urandom_range(255)));
                send_byte(len[15:8], 8'($urandom_range(255)));
                repeat (len + 1) begin
                    // Now and then present the TDO pattern that captures 0x80.
                    if ($urandom_range(7) == 0)
                        tdo = c[3] ? 8'h80 : 8'h01;
                    else
                        tdo = 8'($urandom_range(255));
                    send_byte(8'($urandom_range(255)), tdo);
                end
            end
        end else if (pick < 90) begin
            c = ($urandom_range(1) == 0) ? known[$urandom_range(9)]
                                         : 8'($urandom_range(255, 128));
            send_byte(c, 8'($urandom_range(255)));
            if (c == CMD_SET_LO || c == CMD_SET_HI || c == CMD_DIVISOR) begin
                send_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end else begin
            // Shift command the block must reject.
            c = 8'($urandom_range(255));
            c[7] = 1'b0;
            if ($urandom_range(1) == 0)
                c[0] = 1'b0;
            else
                c[6:4] = 3'b000;
            send_byte(c, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_command();
    endtask

    initial
    begin
        logic [7:0] directed [$] = '{
            8'h00, 8'h81, 8'h83, 8'h84, 8'h85, 8'h87,
            8'h86, 8'hFF, 8'hFF, 8'h8A,
            8'h80, 8'hAA, 8'h55, 8'hFF, 8'h88,
            8'h4B, 8'h04, 8'h06,         // TMS 0,1,1,0,0: walk to Shift-IR
            8'h3B, 8'h07, 8'h41,         // load the special instruction
            8'h29, 8'h00, 8'h00, 8'h5A,  // one-byte read that captures 0x80
            8'h4B, 8'hFF, 8'hFF, 8'h8B   // clamped length, back to reset
        };
        rst_n                = 1'b0;
        host_ch.valid        = 1'b0;
        host_ch.host_byte    = '0;
        host_ch.tdo_samples  = '0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_cycles          = 0;
        bytes_sent           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i], (i == 24) ? 8'h80 : 8'($urandom_range(255)));
        wait_drained();

        run_phase(80, 0, 0);

        // Receiver holds off while commands keep coming, so the input backs up.
        hold_cycles = 400;
        run_phase(40, 0, 0);
        wait_drained();

        run_phase(90, 57, 0);
        run_phase(90, 0, 57);
        run_phase(90, 11, 11);
        run_phase(40, 0, 0);

        wait_drained();
        repeat (20) @(posedge clk);
        foreach (sb.pending_results[i])
            sb.report($sformatf("expected result %0d never arrived", i));

        $display("Run covered %0d host bytes: %0d TCK pulses and %0d reply items checked,",
                 sb.bytes_noted, sb.pulses, sb.replies);
        $display("with pin, divisor, clock mode and TAP tracking; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/jcse_pkg.sv
sv/jcse_if.sv
sv/jcse_ctrl.sv
sv/jcse_dp.sv
sv/jtag_command_shift_engine_core.sv
bench/tb.sv
